[sv/lsmd_pkg.sv]
// Shared constants and register codes for the sector minimum-distance block.
package lsmd_pkg;

  localparam int SECTORS = 16;
  localparam int SEC_W   = (SECTORS > 1) ? $clog2(SECTORS) : 1;
  localparam int QW      = SEC_W + 1;
  localparam int STEP_W  = $clog2(SEC_W + 1);
  localparam int DVW     = 16 + SEC_W;
  localparam int NBYTES  = 2 * SECTORS + 4;
  localparam int BYTE_W  = $clog2(NBYTES);

  localparam logic [7:0]  GRADE_THRESHOLD = 8'd128;
  localparam logic [15:0] EMPTY_DISTANCE  = 16'hFFFF;

  localparam logic [15:0] CONE_RESET  = 16'd36000;
  localparam logic [15:0] WIDTH_RESET = 16'd2250;
  localparam logic [15:0] MAXD_RESET  = 16'd12000;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_CONE_LIMIT   = 3'd0;
  localparam cfg_idx_t REG_SECTOR_WIDTH = 3'd1;
  localparam cfg_idx_t REG_MAX_DISTANCE = 3'd2;
  localparam cfg_idx_t REG_GRADE_FILTER = 3'd3;
  localparam cfg_idx_t REG_HEADER_FIRST = 3'd4;
  localparam cfg_idx_t REG_HEADER_SECOND = 3'd5;
  localparam cfg_idx_t REG_FOOTER       = 3'd6;

  typedef logic [SEC_W-1:0]  sec_t;
  typedef logic [BYTE_W-1:0] byte_idx_t;

endpackage

[sv/lidar_sector_min_distance.sv]
// Top level: range-finder point filter, per-sector minimum store and frame emitter.
//
//  channel | ports                                      | handshake
//  --------+--------------------------------------------+-----------------------------
//  in      | in_mode, in_point_angle/distance/grade     | start & !busy
//  out     | out_frame_byte, out_last_byte              | out_valid, one cycle, no stall
//  cfg     | cfg_index, cfg_data                        | cfg_valid & cfg_ready
//
// Point item: a rejected point keeps busy low, so the next item may follow in the next cycle;
//   a valid point runs a restoring quotient of SEC_W+1 bits (one quotient bit per
//   cycle in ST_DIV), then a RAM read state and a read-modify-write state; busy
//   stays high through ST_DIV, ST_RD and ST_UPD, and the next item may go in once it drops.
// Flush item: 2*SECTORS+4 bytes, one per cycle via the output register; busy stays
//   high in ST_FLUSH and drops as the footer is registered.
// Reset (rst_n low, synchronous) restores state and config registers, clears the count
//   and all sector valid bits; an invalid sector reads as empty (0xFFFF), so no clear pass.
// The receiver cannot stall: bytes leave at one per cycle from the output register.
module lidar_sector_min_distance
  import lsmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // item channel
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [15:0] in_point_angle,
  input  logic [15:0] in_point_distance,
  input  logic [7:0]  in_point_grade,
  // result channel
  output logic        out_valid,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_UPD   = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  localparam byte_idx_t LAST_BYTE  = BYTE_W'(NBYTES - 1);
  localparam byte_idx_t RD_END     = BYTE_W'(2 + 2 * SECTORS);
  localparam logic [QW-1:0] Q_MAX  = QW'(SECTORS - 1);

  // configuration registers
  logic [15:0] cone_r, width_r, maxd_r;
  logic        gfilt_r;
  logic [7:0]  hdr1_r, hdr2_r, footer_r;

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [7:0]        count_r, count_nxt;
  logic [SECTORS-1:0] valid_r, valid_nxt;
  byte_idx_t         byte_r, byte_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  // datapath
  logic [15:0]    rem_r, rem_nxt;
  logic [DVW-1:0] dvs_r, dvs_nxt;
  logic [QW-1:0]  q_r, q_nxt;
  sec_t           sector_r, sector_nxt;
  logic [15:0]    dist_r, dist_nxt;
  logic           gok_r, gok_nxt;
  logic [7:0]     out_byte_r, out_byte_nxt;
  logic           out_last_r, out_last_nxt;

  // RAM port signals
  logic        ram_wr_en, ram_rd_en;
  sec_t        ram_rd_addr;
  logic [15:0] ram_rd_data;

  logic        accept, ge;
  sec_t        sec_clamp, flush_sec, rd_sec;
  byte_idx_t   byte_off, rd_off;
  logic [15:0] cur_min;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // one restoring step: compare remainder with shifted divisor
  assign ge = ({{SEC_W{1'b0}}, rem_r} >= dvs_r);

  // quotient saturates at the last sector
  assign sec_clamp = (q_r > Q_MAX) ? SEC_W'(SECTORS - 1) : q_r[SEC_W-1:0];

  // flush addressing: sector i low byte sits at 3+2i, its read goes out at 2+2i
  assign byte_off  = byte_r - BYTE_W'(3);
  assign flush_sec = byte_off[SEC_W:1];
  assign rd_off    = byte_r - BYTE_W'(2);
  assign rd_sec    = rd_off[SEC_W:1];

  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = sec_clamp;
    if (state_r == ST_RD) begin
      ram_rd_en = 1'b1;
    end else if (state_r == ST_FLUSH && byte_r >= BYTE_W'(2) && byte_r < RD_END
                 && !rd_off[0]) begin
      ram_rd_en   = 1'b1;
      ram_rd_addr = rd_sec;
    end
  end

  // an entry never written since the last clear reads as empty
  always_comb begin
    if (state_r == ST_UPD) begin
      cur_min = valid_r[sector_r] ? ram_rd_data : EMPTY_DISTANCE;
    end else begin
      cur_min = valid_r[flush_sec] ? ram_rd_data : EMPTY_DISTANCE;
    end
  end

  assign ram_wr_en = (state_r == ST_UPD) && gok_r && (dist_r < cur_min);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    valid_nxt     = valid_r;
    byte_nxt      = byte_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    q_nxt         = q_r;
    sector_nxt    = sector_r;
    dist_nxt      = dist_r;
    gok_nxt       = gok_r;
    out_valid_nxt = 1'b0;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode) begin
            byte_nxt  = '0;
            state_nxt = ST_FLUSH;
          end else if (in_point_angle <= cone_r && in_point_distance <= maxd_r) begin
            count_nxt = count_r + 8'd1;
            rem_nxt   = in_point_angle;
            dvs_nxt   = {width_r, {SEC_W{1'b0}}};
            q_nxt     = '0;
            step_nxt  = STEP_W'(SEC_W);
            dist_nxt  = in_point_distance;
            gok_nxt   = !gfilt_r || (in_point_grade > GRADE_THRESHOLD);
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        q_nxt   = {q_r[QW-2:0], ge};
        if (ge) begin
          rem_nxt = rem_r - dvs_r[15:0];
        end
        dvs_nxt = dvs_r >> 1;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        sector_nxt = sec_clamp;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        if (ram_wr_en) begin
          valid_nxt[sector_r] = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_FLUSH: begin
        out_valid_nxt = 1'b1;
        if (byte_r == '0) begin
          out_byte_nxt = hdr1_r;
        end else if (byte_r == BYTE_W'(1)) begin
          out_byte_nxt = hdr2_r;
        end else if (byte_r == BYTE_W'(2)) begin
          out_byte_nxt = count_r;
        end else if (byte_r == LAST_BYTE) begin
          out_byte_nxt = footer_r;
          out_last_nxt = 1'b1;
        end else begin
          out_byte_nxt = byte_off[0] ? cur_min[15:8] : cur_min[7:0];
        end
        byte_nxt = byte_r + BYTE_W'(1);
        if (byte_r == LAST_BYTE) begin
          // frame out: store and count back to empty
          valid_nxt = '0;
          count_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      valid_r     <= '0;
      byte_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      cone_r      <= CONE_RESET;
      width_r     <= WIDTH_RESET;
      maxd_r      <= MAXD_RESET;
      gfilt_r     <= 1'b1;
      hdr1_r      <= '0;
      hdr2_r      <= '0;
      footer_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      valid_r     <= valid_nxt;
      byte_r      <= byte_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CONE_LIMIT:    cone_r   <= cfg_data;
          REG_SECTOR_WIDTH:  width_r  <= cfg_data;
          REG_MAX_DISTANCE:  maxd_r   <= cfg_data;
          REG_GRADE_FILTER:  gfilt_r  <= cfg_data[0];
          REG_HEADER_FIRST:  hdr1_r   <= cfg_data[7:0];
          REG_HEADER_SECOND: hdr2_r   <= cfg_data[7:0];
          REG_FOOTER:        footer_r <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    q_r        <= q_nxt;
    sector_r   <= sector_nxt;
    dist_r     <= dist_nxt;
    gok_r      <= gok_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  lsmd_ram #(
    .WIDTH (16),
    .DEPTH (SECTORS)
  ) u_min_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (sector_r),
    .wr_data (dist_r),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r && out_valid_r;

endmodule

[sv/lsmd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lsmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/lsmd_chk.sv]
// Port-level checker for the sector minimum-distance block, bound to the top level.
module lsmd_chk
  import lsmd_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     in_mode,
  input logic     out_valid,
  input logic     out_last_byte
);

  // footer is always part of a delivered item
  a_last_in_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_byte |-> out_valid)
    else $error("last_byte without out_valid");

  // an accepted flush must raise busy
  a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode) |=> busy)
    else $error("flush accepted but block not busy");

  // nothing follows the footer directly
  a_gap_after_footer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_byte) |=> !out_valid)
    else $error("byte emitted right after footer");

  // a point item never causes output on the next cycle
  a_point_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_mode) |=> !out_valid)
    else $error("output after point item");

endmodule

bind lidar_sector_min_distance lsmd_chk u_lsmd_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_mode       (in_mode),
  .out_valid     (out_valid),
  .out_last_byte (out_last_byte)
);
